// File: rtl/core/nkd_pkg.sv
package nkd_pkg;

	localparam int OP_W       = 2;
	localparam int CHAR_W     = 8;
	localparam int HEAD_CHARS = 8;
	localparam int KEY_CHARS_MAX = HEAD_CHARS + 1;
	localparam int RAW_KEY_W  = KEY_CHARS_MAX * CHAR_W;
	localparam int SECTOR_W   = 10;
	localparam int STATUS_W   = 2;
	localparam int SLOT_W     = 6;

	localparam int ENTRIES_DEF    = 64;
	localparam int NAME_CHARS_DEF = 9;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} nkd_state_t;

	// Search record that moves one cell per cycle along the chain.
	typedef struct packed {
		logic                active;
		logic                hit;
		logic                free;
		logic [SECTOR_W-1:0] sector;
		logic                folder;
	} nkd_tok_t;

	// Update broadcast to every cell; only the addressed cell acts on it.
	typedef struct packed {
		logic wr;
		logic clr;
	} nkd_cmd_t;

	// A name ends at its first zero character; everything after it, and every
	// character at or past the configured name length, reads as zero.
	function automatic logic [RAW_KEY_W-1:0] nkd_norm(input logic [RAW_KEY_W-1:0] raw,
			input int chars);
		logic [RAW_KEY_W-1:0] res;
		logic                 ended;
		res   = raw;
		ended = 1'b0;
		for (int i = 0; i < KEY_CHARS_MAX; i++) begin
			if (ended || i >= chars) begin
				res[CHAR_W*i +: CHAR_W] = '0;
			end else if (raw[CHAR_W*i +: CHAR_W] == '0) begin
				ended = 1'b1;
			end
		end
		return res;
	endfunction

endpackage

// File: rtl/core/nkd_cell.sv
module nkd_cell #(
	parameter int IDX_W    = 6,
	parameter int KEY_W    = 72,
	parameter int CELL_IDX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [KEY_W-1:0]             key,
	input  nkd_pkg::nkd_tok_t            in_tok,
	input  logic [IDX_W-1:0]             in_hit_idx,
	input  logic [IDX_W-1:0]             in_free_idx,
	output nkd_pkg::nkd_tok_t            out_tok,
	output logic [IDX_W-1:0]             out_hit_idx,
	output logic [IDX_W-1:0]             out_free_idx,
	input  nkd_pkg::nkd_cmd_t            cmd,
	input  logic [IDX_W-1:0]             cmd_idx,
	input  logic [KEY_W-1:0]             wr_key,
	input  logic [nkd_pkg::SECTOR_W-1:0] wr_sector,
	input  logic                         wr_folder
);
	import nkd_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                used_q;
	logic [KEY_W-1:0]    key_q;
	logic [SECTOR_W-1:0] sector_q;
	logic                folder_q;
	logic                act_q;
	nkd_tok_t            tok_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [IDX_W-1:0]    free_idx_q;

	logic                match;
	logic                sel;
	nkd_tok_t            tok_nxt;
	logic [IDX_W-1:0]    hit_idx_nxt;
	logic [IDX_W-1:0]    free_idx_nxt;

	assign match = used_q && (key_q == key);
	assign sel   = (cmd_idx == MY_IDX);

	always_comb begin
		tok_nxt      = in_tok;
		hit_idx_nxt  = in_hit_idx;
		free_idx_nxt = in_free_idx;
		if (in_tok.active) begin
			if (!in_tok.hit && match) begin
				tok_nxt.hit    = 1'b1;
				tok_nxt.sector = sector_q;
				tok_nxt.folder = folder_q;
				hit_idx_nxt    = MY_IDX;
			end
			if (!in_tok.free && !used_q) begin
				tok_nxt.free = 1'b1;
				free_idx_nxt = MY_IDX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			act_q  <= 1'b0;
		end else begin
			act_q <= in_tok.active;
			if (sel && cmd.wr) begin
				used_q <= 1'b1;
			end else if (sel && cmd.clr) begin
				used_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q      <= tok_nxt;
		hit_idx_q  <= hit_idx_nxt;
		free_idx_q <= free_idx_nxt;
		if (sel && cmd.wr) begin
			key_q    <= wr_key;
			sector_q <= wr_sector;
			folder_q <= wr_folder;
		end
	end

	always_comb begin
		out_tok        = tok_q;
		out_tok.active = act_q;
	end

	assign out_hit_idx  = hit_idx_q;
	assign out_free_idx = free_idx_q;

endmodule

// File: rtl/core/name_keyed_directory_table.sv
// Channel   Words carried                                         Handshake
// request   operation, key_head, key_tail, new_sector, new_is_folder  req_valid / req_stall
// response  status, slot, found_sector, found_is_folder           rsp_valid / rsp_stall
//
// Each request runs to the end before the next request can be accepted; the result word
// is registered once the search record, walking the chain of entry cells one cell per
// cycle, has left the last cell and the response register is free.
// Reset (arst_n low) clears every used mark at once; there is no clearing pass.
// A response word waiting under rsp_stall does not block a new request from being taken;
// the finished search then waits until the response register is free.
module name_keyed_directory_table #(
	parameter int ENTRIES    = nkd_pkg::ENTRIES_DEF,
	parameter int NAME_CHARS = nkd_pkg::NAME_CHARS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [nkd_pkg::OP_W-1:0]     operation,
	input  logic [63:0]                  key_head,
	input  logic [7:0]                   key_tail,
	input  logic [nkd_pkg::SECTOR_W-1:0] new_sector,
	input  logic                         new_is_folder,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [nkd_pkg::STATUS_W-1:0] status,
	output logic [nkd_pkg::SLOT_W-1:0]   slot,
	output logic [nkd_pkg::SECTOR_W-1:0] found_sector,
	output logic                         found_is_folder
);
	import nkd_pkg::*;

	// Only the characters the name can hold are kept in each entry.
	localparam int KEY_CHARS = (NAME_CHARS < KEY_CHARS_MAX) ? NAME_CHARS : KEY_CHARS_MAX;
	localparam int KEY_W     = KEY_CHARS * CHAR_W;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	nkd_state_t          state_q, state_nxt;
	logic                accept;
	logic                start_q;
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [SECTOR_W-1:0] sector_q;
	logic                folder_q;
	logic [RAW_KEY_W-1:0] key_norm;

	// The chain: link i feeds cell i, link i+1 is what cell i hands on.
	nkd_tok_t            tok      [0:ENTRIES];
	logic [IDX_W-1:0]    hit_idx  [0:ENTRIES];
	logic [IDX_W-1:0]    free_idx [0:ENTRIES];

	nkd_tok_t            fin_tok_q;
	logic [IDX_W-1:0]    fin_hit_idx_q;
	logic [IDX_W-1:0]    fin_free_idx_q;
	logic                capture;
	logic                finish;

	nkd_cmd_t            cmd;
	logic [IDX_W-1:0]    cmd_idx;
	logic [STATUS_W-1:0] res_status;
	logic [SLOT_W-1:0]   res_slot;
	logic [SECTOR_W-1:0] res_sector;
	logic                res_folder;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SECTOR_W-1:0] sector_out_q;
	logic                folder_out_q;

	assign accept   = req_valid && !req_stall;
	assign key_norm = nkd_norm({key_tail, key_head}, NAME_CHARS);

	// Request capture. The key stays on the broadcast bus for the whole sweep.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			key_q    <= key_norm[KEY_W-1:0];
			sector_q <= new_sector;
			folder_q <= new_is_folder;
		end
	end

	assign tok[0]      = '{active: start_q, hit: 1'b0, free: 1'b0, sector: '0, folder: 1'b0};
	assign hit_idx[0]  = '0;
	assign free_idx[0] = '0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		nkd_cell #(
			.IDX_W    (IDX_W),
			.KEY_W    (KEY_W),
			.CELL_IDX (g)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.key          (key_q),
			.in_tok       (tok[g]),
			.in_hit_idx   (hit_idx[g]),
			.in_free_idx  (free_idx[g]),
			.out_tok      (tok[g+1]),
			.out_hit_idx  (hit_idx[g+1]),
			.out_free_idx (free_idx[g+1]),
			.cmd          (cmd),
			.cmd_idx      (cmd_idx),
			.wr_key       (key_q),
			.wr_sector    (sector_q),
			.wr_folder    (folder_q)
		);
	end

	// Next state. The sweep ends when the record leaves the last cell; the
	// result then waits in DONE until the response register can take it.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (tok[ENTRIES].active) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		req_stall = 1'b1;
		capture   = 1'b0;
		finish    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
			end
			ST_SWEEP: begin
				capture = tok[ENTRIES].active;
			end
			ST_DONE: begin
				finish = !rsp_valid_q || !rsp_stall;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			start_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			fin_tok_q      <= tok[ENTRIES];
			fin_hit_idx_q  <= hit_idx[ENTRIES];
			fin_free_idx_q <= free_idx[ENTRIES];
		end
	end

	// Outcome of the finished search, and the update it makes to the table.
	// An add lands in the lowest free entry only when no entry already holds
	// the name; a remove clears the lowest matching entry. Operation code 3
	// behaves as a lookup.
	always_comb begin
		cmd        = '{wr: 1'b0, clr: 1'b0};
		cmd_idx    = fin_hit_idx_q;
		res_status = STAT_NOT_FOUND;
		res_slot   = '0;
		res_sector = '0;
		res_folder = 1'b0;
		case (op_q)
			OP_ADD: begin
				if (fin_tok_q.hit) begin
					res_status = STAT_DUPLICATE;
				end else if (!fin_tok_q.free) begin
					res_status = STAT_FULL;
				end else begin
					res_status = STAT_OK;
					res_slot   = SLOT_W'(fin_free_idx_q);
					cmd_idx    = fin_free_idx_q;
					cmd.wr     = finish;
				end
			end
			OP_REMOVE: begin
				if (fin_tok_q.hit) begin
					res_status = STAT_OK;
					res_slot   = SLOT_W'(fin_hit_idx_q);
					cmd.clr    = finish;
				end
			end
			default: begin
				if (fin_tok_q.hit) begin
					res_status = STAT_OK;
					res_slot   = SLOT_W'(fin_hit_idx_q);
					res_sector = fin_tok_q.sector;
					res_folder = fin_tok_q.folder;
				end
			end
		endcase
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q     <= res_status;
			slot_q       <= res_slot;
			sector_out_q <= res_sector;
			folder_out_q <= res_folder;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign slot            = slot_q;
	assign found_sector    = sector_out_q;
	assign found_is_folder = folder_out_q;

endmodule

// File: rtl/core/nkd_check.sv
module nkd_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_stall,
	input logic                         rsp_valid,
	input logic                         rsp_stall,
	input logic [nkd_pkg::STATUS_W-1:0] status,
	input logic [nkd_pkg::SLOT_W-1:0]   slot,
	input logic [nkd_pkg::SECTOR_W-1:0] found_sector,
	input logic                         found_is_folder
);
	import nkd_pkg::*;

	// A waiting response word holds still.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(slot)
			&& $stable(found_sector) && $stable(found_is_folder))
		else $error("response word changed while stalled");

	// Every failure reports slot zero.
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STAT_OK |-> slot == '0)
		else $error("failed operation reported a nonzero slot");

	// A failed operation reports no lookup data.
	a_fail_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STAT_OK |-> found_sector == '0 && !found_is_folder)
		else $error("failed operation reported entry data");

	// The block is busy right after taking a request, and no result
	// appears in the very next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall && !$rose(rsp_valid))
		else $error("request accepted without the block going busy");

endmodule

bind name_keyed_directory_table nkd_check u_nkd_check (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req_valid),
	.req_stall       (req_stall),
	.rsp_valid       (rsp_valid),
	.rsp_stall       (rsp_stall),
	.status          (status),
	.slot            (slot),
	.found_sector    (found_sector),
	.found_is_folder (found_is_folder)
);
